/* hw/rtl/dss_pkg.sv */
// Shared types and constants for the dual stack shared store unit.
package dss_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int IN_W   = 40;   // op (3) + push_value (32), padded to bytes
	localparam int OUT_W  = 40;   // value (32) + status (2), padded to bytes

	typedef enum logic [2:0] {
		OP_PUSH1 = 3'd0,
		OP_PUSH2 = 3'd1,
		OP_POP1  = 3'd2,
		OP_POP2  = 3'd3,
		OP_DUMP1 = 3'd4,
		OP_DUMP2 = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Controller to datapath.
	typedef struct packed {
		logic take;      // accept the request and run its first step
		logic load_rd;   // move read data into the result register
		logic advance;   // step the dump index and issue the next read
	} dss_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_read;   // offered request needs a store read
		logic in_none;   // offered request gives no result
		logic more;      // dump has further words after the current result
	} dss_stat_t;

endpackage

/* hw/rtl/dss_dpath.sv */
// Datapath: stack counts, shared store, read addressing and result register.
module dss_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dss_pkg::dss_cmd_t           cmd,
	output dss_pkg::dss_stat_t          stat,
	input  logic [dss_pkg::IN_W-1:0]    in_data,
	output logic [dss_pkg::OUT_W-1:0]   out_data,
	output logic                        out_last
);
	import dss_pkg::*;

	localparam logic [ADDR_W-1:0] TOP_ADDR  = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [CNT_W-1:0]  lower_q, upper_q;
	logic [ADDR_W-1:0] idx_q;
	op_t               op_q;

	logic [WORD_W-1:0] value_q;
	status_t           status_q;
	logic              last_q;

	op_t               in_op;
	logic [WORD_W-1:0] in_word;
	logic [CNT_W-1:0]  used;
	logic              room;
	logic [CNT_W-1:0]  dump_cnt;
	logic [CNT_W-1:0]  idx_next_cnt;

	assign in_op   = op_t'(in_data[2:0]);
	assign in_word = in_data[WORD_W+2:3];
	assign used    = lower_q + upper_q;
	assign room    = used < DEPTH_CNT;

	assign dump_cnt     = (op_q == OP_DUMP1) ? lower_q : upper_q;
	assign idx_next_cnt = CNT_W'(idx_q) + CNT_W'(1);

	// Decode the offered request for the controller.
	always_comb begin
		stat.in_read = 1'b0;
		stat.in_none = 1'b0;
		case (in_op)
			OP_POP1, OP_DUMP1: stat.in_read = (lower_q != '0);
			OP_POP2, OP_DUMP2: stat.in_read = (upper_q != '0);
			OP_PUSH1, OP_PUSH2: stat.in_read = 1'b0;
			default: stat.in_none = 1'b1;
		endcase
		stat.more = ((op_q == OP_DUMP1) || (op_q == OP_DUMP2)) && !last_q;
	end

	// Read address: first read of a request, or the next word of a dump.
	always_comb begin
		rd_addr = '0;
		if (cmd.advance) begin
			if (op_q == OP_DUMP1) begin
				rd_addr = idx_q + ADDR_W'(1);
			end else begin
				rd_addr = TOP_ADDR - idx_q - ADDR_W'(1);
			end
		end else begin
			case (in_op)
				OP_POP1:  rd_addr = ADDR_W'(lower_q - CNT_W'(1));
				OP_POP2:  rd_addr = ADDR_W'(DEPTH_CNT - upper_q);
				OP_DUMP1: rd_addr = '0;
				OP_DUMP2: rd_addr = TOP_ADDR;
				default:  rd_addr = '0;
			endcase
		end
	end

	// Shared store: one write port, registered read.
	always_ff @(posedge clk) begin
		if (cmd.take && room) begin
			if (in_op == OP_PUSH1) begin
				mem_q[ADDR_W'(lower_q)] <= in_word;
			end else if (in_op == OP_PUSH2) begin
				mem_q[TOP_ADDR - ADDR_W'(upper_q)] <= in_word;
			end
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Counts and request tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
			op_q    <= OP_PUSH1;
		end else if (cmd.take) begin
			op_q <= in_op;
			case (in_op)
				OP_PUSH1: if (room) lower_q <= lower_q + CNT_W'(1);
				OP_PUSH2: if (room) upper_q <= upper_q + CNT_W'(1);
				OP_POP1:  if (lower_q != '0) lower_q <= lower_q - CNT_W'(1);
				OP_POP2:  if (upper_q != '0) upper_q <= upper_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	// Dump index and result register.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q   <= '0;
			value_q <= '0;
			last_q  <= 1'b1;
			case (in_op)
				OP_PUSH1, OP_PUSH2: status_q <= room ? ST_OK : ST_OVERFLOW;
				OP_POP1, OP_POP2:   status_q <= ST_UNDERFLOW;
				default:            status_q <= ST_EMPTY;
			endcase
		end else if (cmd.load_rd) begin
			value_q  <= rd_data_q;
			status_q <= ST_OK;
			last_q   <= ((op_q == OP_POP1) || (op_q == OP_POP2)) ||
			            (idx_next_cnt == dump_cnt);
		end else if (cmd.advance) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
	end

	assign out_data = {{(OUT_W - WORD_W - 2){1'b0}}, status_q, value_q};
	assign out_last = last_q;

endmodule

/* hw/rtl/dss_ctrl.sv */
// Controller: sequences accept, store read and result handoff.
module dss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  dss_pkg::dss_stat_t  stat,
	output dss_pkg::dss_cmd_t   cmd
);
	import dss_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.take    = (state_q == S_IDLE) && in_valid;
		cmd.load_rd = (state_q == S_READ);
		cmd.advance = (state_q == S_OUT) && out_ready && stat.more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && !stat.in_none) begin
						state_q <= stat.in_read ? S_READ : S_OUT;
					end
				end
				S_READ: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						state_q <= stat.more ? S_READ : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/dual_stack_shared_store_unit.sv */
// Top level: two stacks sharing one store, with stream request and result ports.
//
//   channel   direction  handshake          payload
//   s_*       request    s_tvalid/s_tready  s_tdata: op, push_value
//   m_*       result     m_tvalid/m_tready  m_tdata: value, status; m_tlast: last
//
// A push shows its result in the cycle after it is accepted.
// A pop of a non-empty stack goes through the registered store read before its result.
// A dump gives its words one at a time (store read, then result handoff) while
// m_tready stays high; the store has a single read port.
// Reset (arst_n low) empties both stacks; store contents stay undefined.
// A stalled result holds in the result register; no new request is taken
// until every result of the current request has been taken.
module dual_stack_shared_store_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dss_pkg::IN_W-1:0]   s_tdata,   // [2:0] op, [34:3] push_value
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [dss_pkg::OUT_W-1:0]  m_tdata,   // [31:0] value, [33:32] status
	output logic                       m_tlast
);
	import dss_pkg::*;

	dss_cmd_t  cmd;
	dss_stat_t stat;

	// Sequence each request: accept, optional read, then hand off results.
	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the counts, the store and the result register.
	dss_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);

endmodule

/* tb/sv/tb_dual_stack_shared_store_unit.sv */
// Self-checking testbench for the dual stack shared store unit.
module tb_dual_stack_shared_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dss_pkg::*;

	// Op codes the block must ignore: no result, no state change.
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int HOLD_LEN      = 300;    // long receiver hold-off, in cycles
	localparam int TAIL_CYCLES   = 40;     // quiet time after the last result
	localparam int MAX_REPORTS   = 10;

	// One result as the block should present it.
	typedef struct packed {
		logic [WORD_W-1:0] value;
		status_t           status;
		logic              last;
	} stack_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;

	dual_stack_shared_store_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [2:0] op, [34:3] push_value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] value, [33:32] status
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Own copy of the stack state, tracked request by request.
	logic [WORD_W-1:0] model_store [DEPTH];
	int                lower_depth = 0;
	int                upper_depth = 0;
	stack_result_t     pending_results [$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  request_count  = 0;
	int  result_count   = 0;
	int  dump_count     = 0;
	int  overflow_count = 0;
	int  underflow_count = 0;
	int  empty_dump_count = 0;

	// Idle controls shared by the tests and the receiver process.
	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;
	bit  hold_req   = 1'b0;
	int  hold_cycles = 0;
	int  rx_gap     = 0;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(input bit enable);
		int r;
		r = $urandom_range(0, 99);
		if (!enable || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mix in the signed extremes and the all-zero / all-one words.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'h0000_0000;
		3: return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	// fill_pct biases push against pop so the store swings between full and empty.
	function automatic logic [2:0] pick_op(input int fill_pct);
		int r;
		logic side;
		r = $urandom_range(0, 99);
		side = 1'($urandom_range(0, 1));
		if (r < 2)
			return side ? OP_SPARE7 : OP_SPARE6;
		if (r < 10)
			return side ? OP_DUMP2 : OP_DUMP1;
		if ($urandom_range(0, 99) < fill_pct)
			return side ? OP_PUSH2 : OP_PUSH1;
		return side ? OP_POP2 : OP_POP1;
	endfunction

	task automatic queue_result(input logic [WORD_W-1:0] value, input status_t status,
			input logic last);
		stack_result_t r;
		r.value  = value;
		r.status = status;
		r.last   = last;
		pending_results.push_back(r);
	endtask

	// Work out the results of one accepted request and advance the stack state.
	task automatic predict_stack_results(input logic [2:0] op, input logic [WORD_W-1:0] word);
		int i;
		request_count++;
		case (op)
		OP_PUSH1, OP_PUSH2: begin
			if (lower_depth + upper_depth < DEPTH) begin
				if (op == OP_PUSH1) begin
					model_store[lower_depth] = word;
					lower_depth++;
				end else begin
					upper_depth++;
					model_store[DEPTH - upper_depth] = word;
				end
				queue_result('0, ST_OK, 1'b1);
			end else begin
				overflow_count++;
				queue_result('0, ST_OVERFLOW, 1'b1);
			end
		end
		OP_POP1: begin
			if (lower_depth > 0) begin
				lower_depth--;
				queue_result(model_store[lower_depth], ST_OK, 1'b1);
			end else begin
				underflow_count++;
				queue_result('0, ST_UNDERFLOW, 1'b1);
			end
		end
		OP_POP2: begin
			if (upper_depth > 0) begin
				queue_result(model_store[DEPTH - upper_depth], ST_OK, 1'b1);
				upper_depth--;
			end else begin
				underflow_count++;
				queue_result('0, ST_UNDERFLOW, 1'b1);
			end
		end
		OP_DUMP1: begin
			dump_count++;
			if (lower_depth == 0) begin
				empty_dump_count++;
				queue_result('0, ST_EMPTY, 1'b1);
			end else begin
				// Stack one reads from entry 0 up to its top.
				for (i = 0; i < lower_depth; i++)
					queue_result(model_store[i], ST_OK, i + 1 == lower_depth);
			end
		end
		OP_DUMP2: begin
			dump_count++;
			if (upper_depth == 0) begin
				empty_dump_count++;
				queue_result('0, ST_EMPTY, 1'b1);
			end else begin
				// Stack two reads from the top entry of the store downward.
				for (i = 0; i < upper_depth; i++)
					queue_result(model_store[DEPTH - 1 - i], ST_OK, i + 1 == upper_depth);
			end
		end
		default: ;   // spare codes: nothing happens
		endcase
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Watch both handshakes on the same edge: predict on an accepted request,
	// then check an accepted result against the oldest expectation.
	always @(posedge clk) begin : result_watch
		stack_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_stack_results(s_tdata[2:0], s_tdata[34:3]);
			if (m_tvalid && m_tready) begin
				result_count++;
				if (pending_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result value=%h status=%0d last=%0b",
						m_tdata[31:0], m_tdata[33:32], m_tlast));
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[31:0] !== want.value)
						note_mismatch($sformatf("value expected %h actual %h",
							want.value, m_tdata[31:0]));
					if (m_tdata[33:32] !== want.status)
						note_mismatch($sformatf("status expected %0d actual %0d",
							want.status, m_tdata[33:32]));
					if (m_tlast !== want.last)
						note_mismatch($sformatf("last expected %0b actual %0b",
							want.last, m_tlast));
				end
			end
		end
	end

	// Receiver: random gaps, plus a long hold-off on request from a test.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cycles = HOLD_LEN - 1;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap--;
		end else begin
			m_tready <= 1'b1;
			rx_gap = pick_gap(rx_idle_en);
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("tb_dual_stack_shared_store_unit: errors");
			$finish;
		end
	end

	// Offer one request and hold it until the block takes it. Valid stays high on
	// return so a back-to-back request needs no second assignment in the same step.
	task automatic send_request(input logic [2:0] op, input logic [WORD_W-1:0] word);
		int gap;
		gap = pick_gap(tx_idle_en);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - 35){1'b0}}, word, op};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Drop valid and pause until every expected result has come.
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Empty stacks, spare codes, extreme words, and LIFO order on both sides.
	task automatic test_directed();
		send_request(OP_POP1, 32'h1234_5678);   // underflow, push_value ignored
		send_request(OP_POP2, '0);
		send_request(OP_DUMP1, '0);              // empty dump
		send_request(OP_DUMP2, '1);
		send_request(OP_SPARE6, 32'hdead_beef);  // ignored
		send_request(OP_SPARE7, 32'hffff_ffff);  // ignored
		send_request(OP_PUSH1, 32'h8000_0000);
		send_request(OP_PUSH1, 32'h7fff_ffff);
		send_request(OP_PUSH2, 32'h0000_0000);
		send_request(OP_PUSH2, 32'hffff_ffff);
		send_request(OP_DUMP1, '0);
		send_request(OP_DUMP2, '0);
		send_request(OP_POP1, '0);
		send_request(OP_POP1, '0);
		send_request(OP_POP2, '0);
		send_request(OP_POP2, '0);
		send_request(OP_POP1, '0);
	endtask

	// Fill the store from one side, check overflow on both pushes, dump the full
	// stack, then drain it; repeat from the other side.
	task automatic test_full_store();
		int i;
		for (i = 0; i < DEPTH; i++)
			send_request(OP_PUSH1, pick_word());
		send_request(OP_PUSH1, pick_word());
		send_request(OP_PUSH2, pick_word());
		send_request(OP_DUMP1, '0);
		send_request(OP_DUMP2, '0);
		for (i = 0; i < DEPTH; i++)
			send_request(OP_POP1, '0);
		for (i = 0; i < DEPTH; i++)
			send_request(OP_PUSH2, pick_word());
		send_request(OP_PUSH2, pick_word());
		send_request(OP_PUSH1, pick_word());
		send_request(OP_DUMP2, '0);
		send_request(OP_DUMP1, '0);
		for (i = 0; i < DEPTH; i++)
			send_request(OP_POP2, '0);
	endtask

	// Random traffic in phases of filling, balanced and draining, with one
	// mid-run pause until all results are back. Spare codes do not count.
	task automatic test_random_traffic(input int count);
		int sent;
		int fill_pct;
		logic [2:0] op;
		sent = 0;
		fill_pct = 75;
		while (sent < count) begin
			case ((sent / 40) % 3)
			0: fill_pct = 75;
			1: fill_pct = 50;
			default: fill_pct = 25;
			endcase
			op = pick_op(fill_pct);
			send_request(op, pick_word());
			if (op <= OP_DUMP2) begin
				sent++;
				if (sent == count / 2)
					wait_results_done();
			end
		end
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering,
	// so the block backs up and drops s_tready.
	task automatic test_backpressure();
		int i;
		tx_idle_en = 1'b0;
		hold_req = 1'b1;
		@(posedge clk);
		for (i = 0; i < 20; i++)
			send_request((i % 4 == 3) ? OP_DUMP1 : ((i % 2) ? OP_PUSH2 : OP_PUSH1),
				pick_word());
		tx_idle_en = 1'b1;
	endtask

	// Back-to-back on both sides with no idling at all.
	task automatic test_no_idle();
		int i;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (i = 0; i < 40; i++)
			send_request(pick_op(50), pick_word());
		wait_results_done();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_results_done();
		test_full_store();
		wait_results_done();
		test_random_traffic(236);
		wait_results_done();
		test_backpressure();
		wait_results_done();
		test_no_idle();
		test_random_traffic(20);

		// Drain, then give any stray result time to show up.
		wait_results_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("covered %0d requests and %0d results: %0d dumps (%0d empty),",
			request_count, result_count, dump_count, empty_dump_count);
		$display("  %0d overflows, %0d underflows, %0d mismatches",
			overflow_count, underflow_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb_dual_stack_shared_store_unit: clean");
		end else begin
			$display("tb_dual_stack_shared_store_unit: errors");
		end
		$finish;
	end

endmodule
